FILE: rtl/core/ipv4rhc_pkg.sv
package ipv4rhc_pkg;

    // Configuration register map
    localparam int unsigned CfgAddrW = 8;
    localparam logic [CfgAddrW-1:0] CFG_LOCAL_ADDR = 8'd0;
    localparam logic [CfgAddrW-1:0] CFG_NET_MASK   = 8'd1;

    localparam logic [31:0] LOCAL_ADDR_RST = 32'h0A00_020F;
    localparam logic [31:0] NET_MASK_RST   = 32'hFFFF_FF00;

    // Header geometry
    localparam logic [15:0] MIN_PKT_LEN  = 16'd20;
    localparam logic [5:0]  MIN_HDR_LEN  = 6'd20;
    localparam logic [3:0]  IPV4_VERSION = 4'd4;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

    // Byte positions inside the header
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_TLEN_HI  = 16'd2;
    localparam logic [15:0] POS_TLEN_LO  = 16'd3;
    localparam logic [15:0] POS_PROTO    = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST  = 16'd15;
    localparam logic [15:0] POS_DST_FIRST = 16'd16;
    localparam logic [15:0] POS_DST_LAST  = 16'd19;

    // Protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_VERSION   = 3'd2,
        VERDICT_HDR_LEN   = 3'd3,
        VERDICT_TOT_LEN   = 3'd4,
        VERDICT_CHECKSUM  = 3'd5,
        VERDICT_NOT_OURS  = 3'd6,
        VERDICT_PROTO     = 3'd7
    } t_verdict;

    typedef enum logic [1:0] {
        CLASS_ICMP  = 2'd0,
        CLASS_UDP   = 2'd1,
        CLASS_TCP   = 2'd2,
        CLASS_OTHER = 2'd3
    } t_proto_class;

endpackage

FILE: rtl/core/ipv4rhc_if.sv
// Byte stream into the header checker
interface ipv4rhc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport src (output valid, output data_byte, output last, input ready);
    modport snk (input valid, input data_byte, input last, output ready);
endinterface

// One verdict beat per packet
interface ipv4rhc_res_if;
    logic                      valid;
    logic                      ready;
    ipv4rhc_pkg::t_verdict     verdict;
    ipv4rhc_pkg::t_proto_class proto_class;
    logic [7:0]                protocol_number;
    logic [31:0]               source_addr;
    logic [5:0]                header_bytes;
    logic [15:0]               payload_bytes;

    modport src (output valid, output verdict, output proto_class, output protocol_number,
                 output source_addr, output header_bytes, output payload_bytes,
                 input ready);
    modport snk (input valid, input verdict, input proto_class, input protocol_number,
                 input source_addr, input header_bytes, input payload_bytes,
                 output ready);
    modport mon (input valid, input ready, input verdict, input proto_class,
                 input protocol_number, input source_addr, input header_bytes,
                 input payload_bytes);
endinterface

// Register write channel
interface ipv4rhc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ipv4rhc_pkg::CfgAddrW-1:0] addr;
    logic [31:0]                      data;

    modport src (output valid, output addr, output data, input ready);
    modport snk (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/core/ipv4_receive_header_check_core.sv
// IPv4 receive header check.
// i_byte carries the packet one byte per beat in wire order, starting at the
// first header byte; last marks the final byte. o_res gives one beat per
// packet with the verdict and the captured header fields. i_cfg writes
// local_addr (index 0) and the net mask (index 1); it is always ready and
// should only be written while no packet is in flight.
// Throughput: one byte per cycle, sustained while o_res.ready is high, including back-to-back packets
// of a single byte. The running sum and field capture are updated as each
// byte is taken, so the per-byte work is one 16-bit end-around add.
// Verdict path: the last byte closes the packet into a snapshot register; the
// checks run on the snapshot and their result goes into the output register.
// Stall: the snapshot and output registers hold two finished verdicts; while
// both are full and o_res.ready is low, i_byte.ready drops.
// Reset: clears the byte counter, sum, captured fields and the valid flags,
// and loads local_addr = 10.0.2.15 and the net mask = 255.255.255.0.
module ipv4_receive_header_check_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ipv4rhc_byte_if.snk        i_byte,
    ipv4rhc_cfg_if.snk         i_cfg,
    ipv4rhc_res_if.src         o_res
);

    typedef struct packed {
        logic [15:0] plen;
        logic [15:0] sum;
        logic [7:0]  ver_ihl;
        logic [15:0] tot_len;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
    } t_pkt_snap;

    // Configuration registers
    logic [31:0] r_local_addr;
    logic [31:0] r_net_mask;

    // Per-packet working state
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_sum,        n_sum;
    logic [7:0]  r_pend,       n_pend;
    logic [7:0]  r_ver_ihl,    n_ver_ihl;
    logic [15:0] r_tot_len,    n_tot_len;
    logic [7:0]  r_proto,      n_proto;
    logic [31:0] r_src,        n_src;
    logic [31:0] r_dst,        n_dst;

    // Snapshot of a closed packet
    t_pkt_snap r_snap;
    logic      r_snap_valid;

    // Output register
    logic                      r_out_valid;
    ipv4rhc_pkg::t_verdict     r_verdict;
    ipv4rhc_pkg::t_proto_class r_class;
    logic [7:0]                r_out_proto;
    logic [31:0]               r_out_src;
    logic [5:0]                r_out_hlen;
    logic [15:0]               r_out_payload;

    logic        in_acc;
    logic        out_load;
    logic [7:0]  b;
    logic [15:0] pos;
    logic [5:0]  hlen_w;
    logic        in_hdr;
    logic [16:0] sum_raw;
    logic [15:0] sum_fold;

    logic [5:0]                hlen;
    logic [31:0]               bcast;
    ipv4rhc_pkg::t_proto_class cls;
    ipv4rhc_pkg::t_verdict     verdict;
    logic [15:0]               payload;

    // Handshakes
    assign out_load     = r_snap_valid && (!r_out_valid || o_res.ready);
    assign i_byte.ready = !r_snap_valid || out_load;
    assign in_acc       = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = 1'b1;

    // Field capture and running header sum for the incoming byte
    assign b   = i_byte.data_byte;
    assign pos = r_byte_count;

    always_comb begin
        n_ver_ihl = (pos == ipv4rhc_pkg::POS_VER_IHL) ? b : r_ver_ihl;
        n_tot_len = r_tot_len;
        if (pos == ipv4rhc_pkg::POS_TLEN_HI) begin
            n_tot_len = {b, r_tot_len[7:0]};
        end else if (pos == ipv4rhc_pkg::POS_TLEN_LO) begin
            n_tot_len = {r_tot_len[15:8], b};
        end
        n_proto = (pos == ipv4rhc_pkg::POS_PROTO) ? b : r_proto;
        n_src   = r_src;
        if (pos >= ipv4rhc_pkg::POS_SRC_FIRST && pos <= ipv4rhc_pkg::POS_SRC_LAST) begin
            n_src = {r_src[23:0], b};
        end
        n_dst = r_dst;
        if (pos >= ipv4rhc_pkg::POS_DST_FIRST && pos <= ipv4rhc_pkg::POS_DST_LAST) begin
            n_dst = {r_dst[23:0], b};
        end
        n_byte_count = (pos != ipv4rhc_pkg::COUNT_MAX) ? pos + 16'd1 : pos;
    end

    // Sum covers the first byte always, then bytes below the header length
    assign hlen_w   = {n_ver_ihl[3:0], 2'b00};
    assign in_hdr   = (pos == ipv4rhc_pkg::POS_VER_IHL) || (pos < {10'd0, hlen_w});
    assign sum_raw  = {1'b0, r_sum} + {1'b0, r_pend, b};
    assign sum_fold = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];
    assign n_pend   = (in_hdr && !pos[0]) ? b : r_pend;
    assign n_sum    = (in_hdr && pos[0]) ? sum_fold : r_sum;

    // Checks on the closed packet, first failing check wins
    assign hlen  = {r_snap.ver_ihl[3:0], 2'b00};
    assign bcast = r_local_addr | ~r_net_mask;

    always_comb begin
        unique case (r_snap.proto)
            ipv4rhc_pkg::PROTO_ICMP: cls = ipv4rhc_pkg::CLASS_ICMP;
            ipv4rhc_pkg::PROTO_UDP:  cls = ipv4rhc_pkg::CLASS_UDP;
            ipv4rhc_pkg::PROTO_TCP:  cls = ipv4rhc_pkg::CLASS_TCP;
            default:                 cls = ipv4rhc_pkg::CLASS_OTHER;
        endcase
    end

    always_comb begin
        if (r_snap.plen < ipv4rhc_pkg::MIN_PKT_LEN) begin
            verdict = ipv4rhc_pkg::VERDICT_SHORT;
        end else if (r_snap.ver_ihl[7:4] != ipv4rhc_pkg::IPV4_VERSION) begin
            verdict = ipv4rhc_pkg::VERDICT_VERSION;
        end else if (hlen < ipv4rhc_pkg::MIN_HDR_LEN || {10'd0, hlen} > r_snap.plen) begin
            verdict = ipv4rhc_pkg::VERDICT_HDR_LEN;
        end else if (r_snap.tot_len > r_snap.plen
                     || r_snap.tot_len < {10'd0, hlen}) begin
            verdict = ipv4rhc_pkg::VERDICT_TOT_LEN;
        end else if (r_snap.sum != ipv4rhc_pkg::SUM_GOOD) begin
            verdict = ipv4rhc_pkg::VERDICT_CHECKSUM;
        end else if (r_snap.dst != r_local_addr && r_snap.dst != ipv4rhc_pkg::ADDR_ALL_ONES
                     && r_snap.dst != bcast) begin
            verdict = ipv4rhc_pkg::VERDICT_NOT_OURS;
        end else if (cls == ipv4rhc_pkg::CLASS_OTHER) begin
            verdict = ipv4rhc_pkg::VERDICT_PROTO;
        end else begin
            verdict = ipv4rhc_pkg::VERDICT_ACCEPT;
        end
    end

    assign payload = (verdict == ipv4rhc_pkg::VERDICT_ACCEPT)
                     ? r_snap.tot_len - {10'd0, hlen} : 16'd0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= ipv4rhc_pkg::LOCAL_ADDR_RST;
            r_net_mask   <= ipv4rhc_pkg::NET_MASK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                ipv4rhc_pkg::CFG_LOCAL_ADDR: r_local_addr <= i_cfg.data;
                ipv4rhc_pkg::CFG_NET_MASK:   r_net_mask   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Working state: updated per byte, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_sum        <= '0;
            r_pend       <= '0;
            r_ver_ihl    <= '0;
            r_tot_len    <= '0;
            r_proto      <= '0;
            r_src        <= '0;
            r_dst        <= '0;
        end else if (in_acc) begin
            if (i_byte.last) begin
                r_byte_count <= '0;
                r_sum        <= '0;
                r_pend       <= '0;
                r_ver_ihl    <= '0;
                r_tot_len    <= '0;
                r_proto      <= '0;
                r_src        <= '0;
                r_dst        <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_sum        <= n_sum;
                r_pend       <= n_pend;
                r_ver_ihl    <= n_ver_ihl;
                r_tot_len    <= n_tot_len;
                r_proto      <= n_proto;
                r_src        <= n_src;
                r_dst        <= n_dst;
            end
        end
    end

    // Snapshot stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_acc && i_byte.last) begin
            r_snap_valid <= 1'b1;
        end else if (out_load) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_byte.last) begin
            r_snap.plen    <= n_byte_count;
            r_snap.sum     <= n_sum;
            r_snap.ver_ihl <= n_ver_ihl;
            r_snap.tot_len <= n_tot_len;
            r_snap.proto   <= n_proto;
            r_snap.src     <= n_src;
            r_snap.dst     <= n_dst;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_verdict     <= verdict;
            r_class       <= cls;
            r_out_proto   <= r_snap.proto;
            r_out_src     <= r_snap.src;
            r_out_hlen    <= hlen;
            r_out_payload <= payload;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.verdict         = r_verdict;
    assign o_res.proto_class     = r_class;
    assign o_res.protocol_number = r_out_proto;
    assign o_res.source_addr     = r_out_src;
    assign o_res.header_bytes    = r_out_hlen;
    assign o_res.payload_bytes   = r_out_payload;

endmodule

FILE: rtl/core/ipv4rhc_check.sv
module ipv4rhc_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  ipv4rhc_pkg::t_verdict     i_verdict,
    input  ipv4rhc_pkg::t_proto_class i_proto_class,
    input  logic [5:0]                i_header_bytes,
    input  logic [15:0]               i_payload_bytes
);

    // A stalled verdict beat holds its verdict
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_verdict))
        else $error("verdict beat dropped or changed while stalled");

    // Payload length is only reported for accepted packets
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_payload_bytes != 16'd0
            |-> i_verdict == ipv4rhc_pkg::VERDICT_ACCEPT)
        else $error("payload length on a rejected packet");

    // An accepted packet has a known protocol and a legal header length
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_verdict == ipv4rhc_pkg::VERDICT_ACCEPT
            |-> i_proto_class != ipv4rhc_pkg::CLASS_OTHER
                && i_header_bytes >= ipv4rhc_pkg::MIN_HDR_LEN)
        else $error("accepted packet with bad protocol or header length");

    // Header length is always a whole number of words
    a_hlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_header_bytes[1:0] == 2'b00)
        else $error("header length not a multiple of four");

endmodule

bind ipv4_receive_header_check_core ipv4rhc_check u_ipv4rhc_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_verdict       (o_res.verdict),
    .i_proto_class   (o_res.proto_class),
    .i_header_bytes  (o_res.header_bytes),
    .i_payload_bytes (o_res.payload_bytes)
);

FILE: verif/ipv4rhc_checker.sv
// Watches the byte, register and verdict channels of the header checker,
// predicts one verdict beat per packet and compares it with what comes out.
module ipv4rhc_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ipv4rhc_byte_if i_byte,
    ipv4rhc_cfg_if  i_cfg,
    ipv4rhc_res_if  i_res,
    output int      o_fail_count,
    output int      o_pending
);

    typedef struct {
        ipv4rhc_pkg::t_verdict     verdict;
        ipv4rhc_pkg::t_proto_class cls;
        logic [7:0]                proto;
        logic [31:0]               src;
        logic [5:0]                hdr_bytes;
        logic [15:0]               payload;
    } t_verdict_beat;

    // Register copies
    logic [31:0] own_addr;
    logic [31:0] net_mask;

    // Per-packet receive state
    logic [15:0] byte_cnt;
    logic [16:0] hdr_sum;
    logic [7:0]  word_hi;
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;

    t_verdict_beat verdict_q[$];
    t_verdict_beat want;
    int            fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_rx();
        byte_cnt = '0;
        hdr_sum  = '0;
        word_hi  = '0;
        ver_ihl  = '0;
        tot_len  = '0;
        proto    = '0;
        src      = '0;
        dst      = '0;
    endfunction

    // Absorb one byte; on the last byte queue the verdict it should produce
    function automatic void take_rx_byte(input logic [7:0] b, input logic fin);
        logic [15:0]   pos;
        int            hlen;
        int            plen;
        logic [31:0]   bcast;
        t_verdict_beat beat;

        pos = byte_cnt;
        if (pos == ipv4rhc_pkg::POS_VER_IHL) begin
            ver_ihl = b;
        end else if (pos == ipv4rhc_pkg::POS_TLEN_HI) begin
            tot_len[15:8] = b;
        end else if (pos == ipv4rhc_pkg::POS_TLEN_LO) begin
            tot_len[7:0] = b;
        end else if (pos == ipv4rhc_pkg::POS_PROTO) begin
            proto = b;
        end else if (pos >= ipv4rhc_pkg::POS_SRC_FIRST && pos <= ipv4rhc_pkg::POS_SRC_LAST) begin
            src = {src[23:0], b};
        end else if (pos >= ipv4rhc_pkg::POS_DST_FIRST && pos <= ipv4rhc_pkg::POS_DST_LAST) begin
            dst = {dst[23:0], b};
        end

        // Header words go into the end-around sum, folded at once
        hlen = int'(ver_ihl[3:0]) * 4;
        if (pos == 0 || pos < hlen) begin
            if (!pos[0]) begin
                word_hi = b;
            end else begin
                hdr_sum = hdr_sum + {1'b0, word_hi, b};
                if (hdr_sum > 17'hFFFF) hdr_sum = {1'b0, hdr_sum[15:0]} + 17'd1;
            end
        end

        if (byte_cnt != ipv4rhc_pkg::COUNT_MAX) byte_cnt = byte_cnt + 16'd1;
        if (!fin) return;

        plen  = byte_cnt;
        bcast = own_addr | ~net_mask;

        case (proto)
            ipv4rhc_pkg::PROTO_ICMP: beat.cls = ipv4rhc_pkg::CLASS_ICMP;
            ipv4rhc_pkg::PROTO_UDP:  beat.cls = ipv4rhc_pkg::CLASS_UDP;
            ipv4rhc_pkg::PROTO_TCP:  beat.cls = ipv4rhc_pkg::CLASS_TCP;
            default:                 beat.cls = ipv4rhc_pkg::CLASS_OTHER;
        endcase

        // First failing check wins
        if (plen < ipv4rhc_pkg::MIN_PKT_LEN)
            beat.verdict = ipv4rhc_pkg::VERDICT_SHORT;
        else if (ver_ihl[7:4] != ipv4rhc_pkg::IPV4_VERSION)
            beat.verdict = ipv4rhc_pkg::VERDICT_VERSION;
        else if (hlen < ipv4rhc_pkg::MIN_HDR_LEN || hlen > plen)
            beat.verdict = ipv4rhc_pkg::VERDICT_HDR_LEN;
        else if (tot_len > plen || tot_len < hlen)
            beat.verdict = ipv4rhc_pkg::VERDICT_TOT_LEN;
        else if (hdr_sum[15:0] != ipv4rhc_pkg::SUM_GOOD || hdr_sum[16])
            beat.verdict = ipv4rhc_pkg::VERDICT_CHECKSUM;
        else if (dst != own_addr && dst != ipv4rhc_pkg::ADDR_ALL_ONES && dst != bcast)
            beat.verdict = ipv4rhc_pkg::VERDICT_NOT_OURS;
        else if (beat.cls == ipv4rhc_pkg::CLASS_OTHER)
            beat.verdict = ipv4rhc_pkg::VERDICT_PROTO;
        else
            beat.verdict = ipv4rhc_pkg::VERDICT_ACCEPT;

        beat.proto     = proto;
        beat.src       = src;
        beat.hdr_bytes = hlen[5:0];
        beat.payload   = (beat.verdict == ipv4rhc_pkg::VERDICT_ACCEPT)
                         ? tot_len - 16'(hlen) : 16'd0;
        verdict_q.push_back(beat);
        clear_rx();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_addr = ipv4rhc_pkg::LOCAL_ADDR_RST;
            net_mask = ipv4rhc_pkg::NET_MASK_RST;
            clear_rx();
            verdict_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.addr == ipv4rhc_pkg::CFG_LOCAL_ADDR) own_addr = i_cfg.data;
                else if (i_cfg.addr == ipv4rhc_pkg::CFG_NET_MASK) net_mask = i_cfg.data;
            end

            if (i_byte.valid && i_byte.ready) take_rx_byte(i_byte.data_byte, i_byte.last);

            // Verdict beat against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (verdict_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: verdict beat with no packet pending: v=%0d src=%h",
                                 $realtime, i_res.verdict, i_res.source_addr);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want.verdict   !== i_res.verdict     ||
                        want.cls       !== i_res.proto_class ||
                        want.proto     !== i_res.protocol_number ||
                        want.src       !== i_res.source_addr ||
                        want.hdr_bytes !== i_res.header_bytes ||
                        want.payload   !== i_res.payload_bytes) begin
                        if (fails < 10) begin
                            $display({"%0t: verdict mismatch exp v=%0d cls=%0d pr=%0d",
                                      " src=%h hl=%0d pl=%0d"},
                                     $realtime, want.verdict, want.cls, want.proto, want.src,
                                     want.hdr_bytes, want.payload);
                            $display({"%0t:                  got v=%0d cls=%0d pr=%0d",
                                      " src=%h hl=%0d pl=%0d"},
                                     $realtime, i_res.verdict, i_res.proto_class,
                                     i_res.protocol_number, i_res.source_addr,
                                     i_res.header_bytes, i_res.payload_bytes);
                        end
                        fails++;
                    end
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: verif/tb_ipv4_receive_header_check_core.sv
// Packet stimulus for the IPv4 header checker: directed packets for each
// verdict, then random packet mixes under several address settings.
module tb_ipv4_receive_header_check_core;

    localparam int WDOG_LIMIT  = 1000;
    localparam int PHASE_BYTES = 270;

    typedef enum {
        PKT_GOOD, PKT_TRAILER, PKT_TRUNC, PKT_TINY, PKT_VERSION, PKT_IHL_LOW,
        PKT_IHL_OVER, PKT_TLEN_OVER, PKT_TLEN_UNDER, PKT_CSUM, PKT_FOREIGN,
        PKT_PROTO, PKT_NOISE
    } t_pkt_kind;

    logic clk = 1'b0;
    logic rst_n;

    ipv4rhc_byte_if rx_bytes();
    ipv4rhc_cfg_if  cfg_wr();
    ipv4rhc_res_if  verdicts();

    int          fail_total;
    int          pend_total;
    int          bytes_sent;
    int          hold_left   = 0;
    int          quiet_cycles = 0;
    bit          idle_on     = 1'b1;
    logic [31:0] cur_local   = ipv4rhc_pkg::LOCAL_ADDR_RST;
    logic [31:0] cur_mask    = ipv4rhc_pkg::NET_MASK_RST;
    logic [7:0]  pkt_q[$];

    always #6 clk = ~clk;

    ipv4_receive_header_check_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (rx_bytes),
        .i_cfg   (cfg_wr),
        .o_res   (verdicts)
    );

    ipv4rhc_checker u_hdr_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte       (rx_bytes),
        .i_cfg        (cfg_wr),
        .i_res        (verdicts),
        .o_fail_count (fail_total),
        .o_pending    (pend_total)
    );

    // Verdict sink: while idle_on is set, ready drops in random bursts
    always @(posedge clk) begin
        if (hold_left > 0) begin
            verdicts.ready <= 1'b0;
            hold_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            verdicts.ready <= 1'b0;
            hold_left = $urandom_range(0, 3);
        end else begin
            verdicts.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk) begin
        if (!rst_n || (rx_bytes.valid && rx_bytes.ready) || (cfg_wr.valid && cfg_wr.ready) ||
            (verdicts.valid && verdicts.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WDOG_LIMIT) begin
                $display("watchdog expired at %0t", $realtime);
                $display("tb_ipv4_receive_header_check_core failed");
                $finish;
            end
        end
    end

    // Build one packet into pkt_q: valid header with random content, then at most one flaw
    task automatic make_packet(input t_pkt_kind kind);
        int          ihl;
        int          hlen;
        int          pay;
        int          plen;
        int          k;
        int          v;
        logic [15:0] tlen;
        logic [7:0]  hdr[60];
        logic [31:0] dst;
        logic [31:0] bcast;
        logic [16:0] sum;
        logic [7:0]  proto;

        pkt_q.delete();
        bcast = cur_local | ~cur_mask;
        ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        if (kind == PKT_IHL_OVER) ihl = $urandom_range(6, 15);
        hlen = ihl * 4;
        pay  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
        tlen = 16'(hlen + pay);
        plen = hlen + pay;

        case (kind)
            PKT_TRAILER:    plen = plen + $urandom_range(1, 12);
            PKT_TRUNC:      plen = $urandom_range(1, plen - 1);
            PKT_TINY:       plen = $urandom_range(1, 19);
            PKT_IHL_OVER:   plen = $urandom_range(20, hlen - 1);
            PKT_TLEN_OVER:  tlen = tlen + 16'($urandom_range(1, 100));
            PKT_TLEN_UNDER: tlen = 16'($urandom_range(0, hlen - 1));
            PKT_NOISE:      plen = $urandom_range(1, 60);
            default: ;
        endcase

        case ($urandom_range(0, 2))
            0:       proto = ipv4rhc_pkg::PROTO_ICMP;
            1:       proto = ipv4rhc_pkg::PROTO_UDP;
            default: proto = ipv4rhc_pkg::PROTO_TCP;
        endcase
        if (kind == PKT_PROTO) begin
            do proto = 8'($urandom);
            while (proto == ipv4rhc_pkg::PROTO_ICMP || proto == ipv4rhc_pkg::PROTO_UDP
                   || proto == ipv4rhc_pkg::PROTO_TCP);
        end

        case ($urandom_range(0, 2))
            0:       dst = cur_local;
            1:       dst = ipv4rhc_pkg::ADDR_ALL_ONES;
            default: dst = bcast;
        endcase
        if (kind == PKT_FOREIGN) begin
            do dst = $urandom;
            while (dst == cur_local || dst == ipv4rhc_pkg::ADDR_ALL_ONES || dst == bcast);
        end

        for (k = 0; k < hlen; k++) hdr[k] = 8'($urandom);
        hdr[0]  = {ipv4rhc_pkg::IPV4_VERSION, 4'(ihl)};
        hdr[2]  = tlen[15:8];
        hdr[3]  = tlen[7:0];
        hdr[9]  = proto;
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
        if (kind == PKT_VERSION) begin
            do v = $urandom_range(0, 15);
            while (v == int'(ipv4rhc_pkg::IPV4_VERSION));
            hdr[0][7:4] = 4'(v);
        end
        if (kind == PKT_IHL_LOW) hdr[0][3:0] = 4'($urandom_range(0, 4));

        // Checksum over the built header
        sum = '0;
        for (k = 0; k < hlen; k += 2) begin
            sum = sum + {1'b0, hdr[k], hdr[k+1]};
            if (sum > 17'hFFFF) sum = {1'b0, sum[15:0]} + 17'd1;
        end
        {hdr[10], hdr[11]} = ~sum[15:0];
        if (kind == PKT_CSUM) hdr[11] = hdr[11] ^ 8'($urandom_range(1, 255));

        for (k = 0; k < plen; k++) begin
            if (kind != PKT_NOISE && k < hlen) pkt_q.push_back(hdr[k]);
            else pkt_q.push_back(8'($urandom));
        end
    endtask

    // One byte beat, with an occasional gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic fin, input bit calm);
        if (idle_on && !calm && $urandom_range(0, 11) == 0) begin
            rx_bytes.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        rx_bytes.valid     <= 1'b1;
        rx_bytes.data_byte <= b;
        rx_bytes.last      <= fin;
        do @(posedge clk);
        while (!rx_bytes.ready);
    endtask

    task automatic send_packet();
        int k;
        bit calm;

        calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < pkt_q.size(); k++) send_byte(pkt_q[k], k == pkt_q.size() - 1, calm);
        bytes_sent += pkt_q.size();
    endtask

    // Hold the byte stream until every verdict is out, then let the pipe settle
    task automatic settle(input int tail);
        rx_bytes.valid <= 1'b0;
        do @(posedge clk);
        while (pend_total != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [ipv4rhc_pkg::CfgAddrW-1:0] idx,
                             input logic [31:0] val);
        cfg_wr.valid <= 1'b1;
        cfg_wr.addr  <= idx;
        cfg_wr.data  <= val;
        do @(posedge clk);
        while (!cfg_wr.ready);
        cfg_wr.valid <= 1'b0;
        if (idx == ipv4rhc_pkg::CFG_LOCAL_ADDR) cur_local = val;
        else cur_mask = val;
        @(posedge clk);
    endtask

    initial begin
        t_pkt_kind plan[$];
        t_pkt_kind kind;
        int        phase;
        int        r;
        int        start_bytes;
        logic [31:0] new_local;
        logic [31:0] new_mask;

        rst_n              = 1'b0;
        rx_bytes.valid     = 1'b0;
        rx_bytes.data_byte = 8'h00;
        rx_bytes.last      = 1'b0;
        cfg_wr.valid       = 1'b0;
        cfg_wr.addr        = ipv4rhc_pkg::CFG_LOCAL_ADDR;
        cfg_wr.data        = 32'h0;
        bytes_sent         = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two single-byte packets, at both byte extremes
        pkt_q = '{8'hFF};
        send_packet();
        pkt_q = '{8'h00};
        send_packet();

        // Directed: each packet kind at least once, good packets three times
        plan = '{PKT_GOOD, PKT_GOOD, PKT_GOOD, PKT_TINY, PKT_TRUNC, PKT_VERSION,
                 PKT_IHL_LOW, PKT_IHL_OVER, PKT_TLEN_OVER, PKT_TLEN_UNDER, PKT_CSUM,
                 PKT_FOREIGN, PKT_PROTO, PKT_TRAILER, PKT_NOISE};
        foreach (plan[i]) begin
            make_packet(plan[i]);
            send_packet();
        end

        // Random mixes, each under its own address setting
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    new_local = $urandom;
                    new_mask  = ~((32'h1 << $urandom_range(2, 24)) - 32'h1);
                end
                1: begin
                    new_local = 32'h0;
                    new_mask  = 32'h0;
                end
                2: begin
                    new_local = 32'hFFFF_FFFF;
                    new_mask  = 32'hFFFF_FFFF;
                end
                3: begin
                    new_local = $urandom;
                    new_mask  = $urandom;
                end
                default: begin
                    new_local = $urandom;
                    new_mask  = ipv4rhc_pkg::NET_MASK_RST;
                end
            endcase
            settle(4);
            if (phase == 4) idle_on = 1'b0;
            cfg_write(ipv4rhc_pkg::CFG_LOCAL_ADDR, new_local);
            cfg_write(ipv4rhc_pkg::CFG_NET_MASK, new_mask);

            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 55)      kind = PKT_GOOD;
                else if (r < 62) kind = PKT_TRAILER;
                else if (r < 67) kind = PKT_TRUNC;
                else if (r < 70) kind = PKT_TINY;
                else if (r < 73) kind = PKT_VERSION;
                else if (r < 76) kind = PKT_IHL_LOW;
                else if (r < 79) kind = PKT_IHL_OVER;
                else if (r < 82) kind = PKT_TLEN_OVER;
                else if (r < 85) kind = PKT_TLEN_UNDER;
                else if (r < 89) kind = PKT_CSUM;
                else if (r < 93) kind = PKT_FOREIGN;
                else if (r < 96) kind = PKT_PROTO;
                else             kind = PKT_NOISE;
                make_packet(kind);
                send_packet();
                if (idle_on && $urandom_range(0, 14) == 0) settle(0);
            end
        end

        settle(8);
        if (fail_total == 0 && pend_total == 0) begin
            $display("tb_ipv4_receive_header_check_core passed");
        end else begin
            $display("tb_ipv4_receive_header_check_core failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ipv4rhc_pkg.sv
rtl/core/ipv4rhc_if.sv
rtl/core/ipv4_receive_header_check_core.sv
rtl/core/ipv4rhc_check.sv
verif/ipv4rhc_checker.sv
verif/tb_ipv4_receive_header_check_core.sv
